// File: hw/rtl/slcp_pkg.sv
package slcp_pkg;

    // Reset values of the configuration registers.
    localparam logic [7:0] SYNC_RESET   = 8'h60;
    localparam logic [7:0] PIXELS_RESET = 8'd50;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_VALUE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXELS      = 1'b1;

    // Command byte codes.
    localparam logic [7:0] CMD_STRIP0 = 8'd0;
    localparam logic [7:0] CMD_STRIP1 = 8'd1;
    localparam logic [7:0] CMD_UV1    = 8'd2;
    localparam logic [7:0] CMD_UV2    = 8'd3;
    localparam logic [7:0] CMD_RGB    = 8'd4;

    // Result kinds.
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_PWM   = 1'b1;

    // PWM channel codes.
    localparam logic [2:0] CH_UV1   = 3'd0;
    localparam logic [2:0] CH_UV2   = 3'd1;
    localparam logic [2:0] CH_RED   = 3'd2;
    localparam logic [2:0] CH_GREEN = 3'd3;
    localparam logic [2:0] CH_BLUE  = 3'd4;

    // Byte positions inside a three-byte group.
    localparam logic [1:0] BP_FIRST  = 2'd0;
    localparam logic [1:0] BP_SECOND = 2'd1;
    localparam logic [1:0] BP_THIRD  = 2'd2;

    localparam int unsigned OUT_DATA_W = 48;

    typedef enum logic [5:0] {
        PH_HUNT  = 6'b000001,
        PH_CMD   = 6'b000010,
        PH_PIXEL = 6'b000100,
        PH_UV1   = 6'b001000,
        PH_UV2   = 6'b010000,
        PH_RGB   = 6'b100000
    } t_phase;

endpackage

// File: hw/rtl/serial_led_command_parser.sv
// Serial LED command parser. Received bytes arrive one per transfer on the
// slave stream. The parser hunts for the sync byte, reads a command byte and
// then the payload: commands 0 and 1 load strip 0 or 1 with one pixel write
// per three payload bytes (the last pixel of the strip carries tlast), commands
// 2 and 3 set the UV1 or UV2 PWM level from one byte, and command 4 sets the
// red, green and blue levels from three bytes. Any other command drops the
// frame. The parser state and a single output register are updated at the edge
// where the byte transfer happens, so one byte is accepted every clock as long
// as the output register is empty or is being drained in the same cycle. A
// result is registered and appears in the cycle after the byte that completes
// it. Configuration writes take effect on the next byte.
module serial_led_command_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [slcp_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [7:0]                          i_cfg_wdata,
    // Received bytes.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // rx_byte[7:0]
    // Results.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0 up: strip_select[0], pixel_index[8:1],
    // pixel_color[32:9], pwm_channel[35:33], pwm_level[43:36], zero fill.
    output logic [slcp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tuser,  // result_kind
    output logic                                m_axis_tlast   // latch_strip
);

    // Configuration registers.
    logic [7:0] r_sync_value;
    logic [7:0] r_pixels;

    // Parser state.
    slcp_pkg::t_phase r_phase, n_phase;
    logic       r_strip,   n_strip;
    logic [7:0] r_counter, n_counter;
    logic [1:0] r_bphase,  n_bphase;
    logic [7:0] r_first,   n_first;
    logic [7:0] r_second,  n_second;

    // Output register.
    logic                              r_out_valid, n_out_valid;
    logic [slcp_pkg::OUT_DATA_W-1:0]   r_out_data,  n_out_data;
    logic                              r_out_kind,  n_out_kind;
    logic                              r_out_last,  n_out_last;

    // Result of the current byte, before it is loaded into the output register.
    logic        emit;
    logic        res_kind;
    logic        res_strip;
    logic [7:0]  res_index;
    logic [23:0] res_color;
    logic        res_last;
    logic [2:0]  res_channel;
    logic [7:0]  res_level;

    logic        in_xfer;
    logic        out_xfer;
    logic        last_pixel;
    logic [7:0]  b;

    // The output register frees up in the same cycle it is drained.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = r_out_valid && m_axis_tready;
    assign b             = s_axis_tdata;

    // The pixel is the last one when its index plus one reaches the count,
    // which also covers a count lowered in the middle of a frame.
    assign last_pixel = ({1'b0, r_counter} + 9'd1) >= {1'b0, r_pixels};

    always_comb begin
        n_phase     = r_phase;
        n_strip     = r_strip;
        n_counter   = r_counter;
        n_bphase    = r_bphase;
        n_first     = r_first;
        n_second    = r_second;
        emit        = 1'b0;
        res_kind    = slcp_pkg::KIND_PIXEL;
        res_strip   = 1'b0;
        res_index   = 8'd0;
        res_color   = 24'd0;
        res_last    = 1'b0;
        res_channel = slcp_pkg::CH_UV1;
        res_level   = 8'd0;

        unique case (r_phase)
            slcp_pkg::PH_HUNT: begin
                if (b == r_sync_value) begin
                    n_phase = slcp_pkg::PH_CMD;
                end
            end
            slcp_pkg::PH_CMD: begin
                n_bphase  = slcp_pkg::BP_FIRST;
                n_counter = 8'd0;
                unique case (b) inside
                    slcp_pkg::CMD_STRIP0, slcp_pkg::CMD_STRIP1: begin
                        n_strip = b[0];
                        n_phase = (r_pixels == 8'd0) ? slcp_pkg::PH_HUNT
                                                     : slcp_pkg::PH_PIXEL;
                    end
                    slcp_pkg::CMD_UV1: n_phase = slcp_pkg::PH_UV1;
                    slcp_pkg::CMD_UV2: n_phase = slcp_pkg::PH_UV2;
                    slcp_pkg::CMD_RGB: n_phase = slcp_pkg::PH_RGB;
                    default:           n_phase = slcp_pkg::PH_HUNT;
                endcase
            end
            slcp_pkg::PH_PIXEL: begin
                if (r_bphase == slcp_pkg::BP_FIRST) begin
                    n_first  = b;
                    n_bphase = slcp_pkg::BP_SECOND;
                end else if (r_bphase == slcp_pkg::BP_SECOND) begin
                    n_second = b;
                    n_bphase = slcp_pkg::BP_THIRD;
                end else begin
                    emit      = 1'b1;
                    res_kind  = slcp_pkg::KIND_PIXEL;
                    res_strip = r_strip;
                    res_index = r_counter;
                    res_color = {r_second, r_first, b};
                    res_last  = last_pixel;
                    n_bphase  = slcp_pkg::BP_FIRST;
                    n_counter = r_counter + 8'd1;
                    if (last_pixel) begin
                        n_phase = slcp_pkg::PH_HUNT;
                    end
                end
            end
            slcp_pkg::PH_UV1: begin
                emit        = 1'b1;
                res_kind    = slcp_pkg::KIND_PWM;
                res_channel = slcp_pkg::CH_UV1;
                res_level   = b;
                n_phase     = slcp_pkg::PH_HUNT;
            end
            slcp_pkg::PH_UV2: begin
                emit        = 1'b1;
                res_kind    = slcp_pkg::KIND_PWM;
                res_channel = slcp_pkg::CH_UV2;
                res_level   = b;
                n_phase     = slcp_pkg::PH_HUNT;
            end
            slcp_pkg::PH_RGB: begin
                emit      = 1'b1;
                res_kind  = slcp_pkg::KIND_PWM;
                res_level = b;
                if (r_bphase >= slcp_pkg::BP_THIRD) begin
                    res_channel = slcp_pkg::CH_BLUE;
                    n_bphase    = slcp_pkg::BP_FIRST;
                    n_phase     = slcp_pkg::PH_HUNT;
                end else begin
                    res_channel = (r_bphase == slcp_pkg::BP_FIRST) ? slcp_pkg::CH_RED
                                                                   : slcp_pkg::CH_GREEN;
                    n_bphase    = r_bphase + 2'd1;
                end
            end
            default: begin
                n_phase = slcp_pkg::PH_HUNT;
            end
        endcase
    end

    // Output register: load on a byte that produces a result, clear when
    // drained without a new result behind it.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;
        if (out_xfer) begin
            n_out_valid = 1'b0;
        end
        if (in_xfer && emit) begin
            n_out_valid = 1'b1;
            n_out_data  = {4'd0, res_level, res_channel, res_color, res_index, res_strip};
            n_out_kind  = res_kind;
            n_out_last  = res_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value <= slcp_pkg::SYNC_RESET;
            r_pixels     <= slcp_pkg::PIXELS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                slcp_pkg::REG_SYNC_VALUE: r_sync_value <= i_cfg_wdata;
                slcp_pkg::REG_PIXELS:     r_pixels     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= slcp_pkg::PH_HUNT;
            r_strip   <= 1'b0;
            r_counter <= 8'd0;
            r_bphase  <= slcp_pkg::BP_FIRST;
            r_first   <= 8'd0;
            r_second  <= 8'd0;
        end else if (in_xfer) begin
            r_phase   <= n_phase;
            r_strip   <= n_strip;
            r_counter <= n_counter;
            r_bphase  <= n_bphase;
            r_first   <= n_first;
            r_second  <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_kind <= n_out_kind;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule
